[rtl/cpr_pkg.sv]
// constants, types and helper functions shared by the clock page replacement block
// no dependencies; every other rtl file refers to it by scoped names
`default_nettype none

package cpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 20;
  localparam int CFG_W     = 5;
  localparam int FRAME_W   = 4;
  localparam int HIT_W     = 32;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FILL_W    = $clog2(FRAMES + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [HIT_W-1:0]     hits_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_EVICT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    page_t wdata;
    idx_t  raddr;
  } mem_req_t;

  // frame count register clamped to 1..FRAMES
  function automatic fill_t active_frames(input logic [CFG_W-1:0] cfg);
    int n;
    n = int'(cfg);
    if (n == 0) n = 1;
    if (n > FRAMES) n = FRAMES;
    return fill_t'(n);
  endfunction

  // step a frame index, wrapping at limit
  function automatic fill_t wrap_next(input fill_t h, input fill_t limit);
    fill_t nxt;
    nxt = h + fill_t'(1);
    return (nxt < limit) ? nxt : '0;
  endfunction

endpackage

`default_nettype wire

[rtl/cpr_if.sv]
// valid/ready channel interfaces for page accesses and replacement results
// depends on cpr_pkg for field widths
`default_nettype none

interface cpr_page_if;
  logic                        valid;
  logic                        ready;
  logic [cpr_pkg::PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface cpr_result_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [cpr_pkg::FRAME_W-1:0]   frame;
  logic                          evicted;
  logic [cpr_pkg::PAGE_BITS-1:0] evicted_page;
  logic [cpr_pkg::HIT_W-1:0]     hit_count;

  modport source (output valid, output hit, output frame, output evicted,
                  output evicted_page, output hit_count, input ready);
  modport sink   (input valid, input hit, input frame, input evicted,
                  input evicted_page, input hit_count, output ready);
endinterface

`default_nettype wire

[rtl/cpr_page_mem.sv]
// page store: one write port and one read port, read data registered
// depends on cpr_pkg for the request struct and widths
`default_nettype none

module cpr_page_mem (
  input  wire logic              clk_i,
  input  wire cpr_pkg::mem_req_t req_i,
  output cpr_pkg::page_t         rdata_o
);

  cpr_pkg::page_t mem [cpr_pkg::FRAMES];
  cpr_pkg::page_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/clock_page_replacement.sv]
// clock page replacement: sequencer, reference bits, counters and result register
// depends on cpr_pkg, cpr_if (cpr_page_if, cpr_result_if) and cpr_page_mem
//
//   channel     dir   handshake       payload
//   page_in     in    valid/ready     page_number
//   result_out  out   valid/ready     hit, frame, evicted, evicted_page, hit_count
//   cfg         in    cfg_we_i        cfg_wdata_i (frames_in_use)
//
// the page store is scanned one frame per cycle through its read port; a hit ends the
// scan, a fill writes the next free frame, and a full miss sweeps from the hand,
// clearing set reference bits, then captures the victim's old page as it evicts it;
// each item is accepted in idle and then scanned.
// reset leaves no frames resident and all reference bits clear; no clearing pass.
// a new item is taken in idle while the previous result may still wait for ready.
`default_nettype none

module clock_page_replacement (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cpr_pkg::CFG_W-1:0]   cfg_wdata_i,
  cpr_page_if.sink                         page_in,
  cpr_result_if.source                     result_out
);

  cpr_pkg::state_e state_q, state_d;

  logic [cpr_pkg::CFG_W-1:0]  cfg_q;
  logic [cpr_pkg::FRAMES-1:0] ref_q;
  cpr_pkg::fill_t             filled_q;
  cpr_pkg::fill_t             hand_q;
  cpr_pkg::fill_t             idx_q;
  cpr_pkg::fill_t             sweep_q;
  cpr_pkg::idx_t              rd_idx_q;
  logic                       rd_pend_q;
  cpr_pkg::hits_t             hits_q;
  cpr_pkg::page_t             page_q;
  cpr_pkg::idx_t              slot_q;
  logic                       hit_q;
  logic                       evicted_q;
  cpr_pkg::page_t             old_q;

  logic                       out_valid_q;
  logic                       out_hit_q;
  logic [cpr_pkg::FRAME_W-1:0] out_frame_q;
  logic                       out_evicted_q;
  cpr_pkg::page_t             out_evicted_page_q;
  cpr_pkg::hits_t             out_hit_count_q;

  cpr_pkg::mem_req_t mem_req;
  cpr_pkg::page_t    mem_rdata;
  cpr_pkg::fill_t    n_frames;
  logic              accept;
  logic              rd_hit;
  logic              scan_done;
  logic              fill_ok;
  logic              sweep_set;
  logic              out_free;

  cpr_page_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign n_frames  = cpr_pkg::active_frames(cfg_q);
  assign accept    = page_in.valid && page_in.ready;
  assign rd_hit    = rd_pend_q && (mem_rdata == page_q);
  assign scan_done = (idx_q >= filled_q) && !rd_pend_q;
  assign fill_ok   = filled_q < n_frames;
  assign sweep_set = ref_q[cpr_pkg::idx_t'(sweep_q)];
  assign out_free  = !out_valid_q || result_out.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpr_pkg::ST_IDLE: begin
        if (accept) state_d = cpr_pkg::ST_SCAN;
      end
      cpr_pkg::ST_SCAN: begin
        if (rd_hit) begin
          state_d = cpr_pkg::ST_DONE;
        end else if (scan_done) begin
          state_d = fill_ok ? cpr_pkg::ST_DONE : cpr_pkg::ST_SWEEP;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (!sweep_set) state_d = cpr_pkg::ST_EVICT;
      end
      cpr_pkg::ST_EVICT: begin
        state_d = cpr_pkg::ST_DONE;
      end
      cpr_pkg::ST_DONE: begin
        if (out_free) state_d = cpr_pkg::ST_IDLE;
      end
      default: state_d = cpr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: input ready and page store port
  always_comb begin
    page_in.ready = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = slot_q;
    mem_req.wdata = page_q;
    mem_req.raddr = cpr_pkg::idx_t'(idx_q);
    unique case (state_q)
      cpr_pkg::ST_IDLE: begin
        page_in.ready = 1'b1;
      end
      cpr_pkg::ST_SCAN: begin
        if (!rd_hit && scan_done && fill_ok) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cpr_pkg::idx_t'(filled_q);
        end
      end
      cpr_pkg::ST_SWEEP: begin
        mem_req.raddr = cpr_pkg::idx_t'(sweep_q);
      end
      cpr_pkg::ST_EVICT: begin
        mem_req.we = 1'b1;
      end
      cpr_pkg::ST_DONE: begin
        mem_req.we = 1'b0;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cpr_pkg::ST_IDLE;
      cfg_q    <= cpr_pkg::CFG_W'(cpr_pkg::FRAMES);
      ref_q    <= '0;
      filled_q <= '0;
      hand_q   <= '0;
      hits_q   <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      unique case (state_q)
        cpr_pkg::ST_IDLE: begin
          rd_pend_q <= 1'b0;
        end
        cpr_pkg::ST_SCAN: begin
          rd_pend_q <= (idx_q < filled_q) && !rd_hit;
          if (rd_hit) begin
            ref_q[rd_idx_q] <= 1'b1;
            if (hits_q != '1) hits_q <= hits_q + cpr_pkg::hits_t'(1);
          end else if (scan_done && fill_ok) begin
            ref_q[cpr_pkg::idx_t'(filled_q)] <= 1'b1;
            filled_q <= filled_q + cpr_pkg::fill_t'(1);
            hand_q   <= cpr_pkg::wrap_next(hand_q, n_frames);
          end
        end
        cpr_pkg::ST_SWEEP: begin
          // second chance: clear the bit and move on
          if (sweep_set) ref_q[cpr_pkg::idx_t'(sweep_q)] <= 1'b0;
        end
        cpr_pkg::ST_EVICT: begin
          ref_q[slot_q] <= 1'b1;
          hand_q <= cpr_pkg::wrap_next(cpr_pkg::fill_t'(slot_q), filled_q);
        end
        cpr_pkg::ST_DONE: begin
          rd_pend_q <= 1'b0;
        end
        default: begin
          rd_pend_q <= 1'b0;
        end
      endcase
    end
  end

  // item payload and scan pointers
  always_ff @(posedge clk_i) begin
    case (state_q)
      cpr_pkg::ST_IDLE: begin
        page_q    <= page_in.page_number;
        idx_q     <= '0;
        hit_q     <= 1'b0;
        evicted_q <= 1'b0;
        old_q     <= '0;
      end
      cpr_pkg::ST_SCAN: begin
        idx_q    <= idx_q + cpr_pkg::fill_t'(1);
        rd_idx_q <= cpr_pkg::idx_t'(idx_q);
        sweep_q  <= (hand_q >= filled_q) ? '0 : hand_q;
        if (rd_hit) begin
          hit_q  <= 1'b1;
          slot_q <= rd_idx_q;
        end else if (scan_done) begin
          slot_q <= cpr_pkg::idx_t'(filled_q);
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (sweep_set) begin
          sweep_q <= cpr_pkg::wrap_next(sweep_q, filled_q);
        end else begin
          slot_q <= cpr_pkg::idx_t'(sweep_q);
        end
      end
      cpr_pkg::ST_EVICT: begin
        evicted_q <= 1'b1;
        old_q     <= mem_rdata;
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == cpr_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cpr_pkg::ST_DONE && out_free) begin
      out_hit_q          <= hit_q;
      out_frame_q        <= cpr_pkg::FRAME_W'(slot_q);
      out_evicted_q      <= evicted_q;
      out_evicted_page_q <= old_q;
      out_hit_count_q    <= hits_q;
    end
  end

  assign result_out.valid        = out_valid_q;
  assign result_out.hit          = out_hit_q;
  assign result_out.frame        = out_frame_q;
  assign result_out.evicted      = out_evicted_q;
  assign result_out.evicted_page = out_evicted_page_q;
  assign result_out.hit_count    = out_hit_count_q;

`ifndef SYNTHESIS
  // page store writes only happen at the end of a fill or an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == cpr_pkg::ST_SCAN || state_q == cpr_pkg::ST_EVICT))
    else $error("page store written outside fill or eviction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == cpr_pkg::ST_SCAN)
    else $error("accepted item did not start a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != cpr_pkg::ST_IDLE |=> hits_q >= $past(hits_q))
    else $error("hit count went backward");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= cpr_pkg::fill_t'(cpr_pkg::FRAMES) && filled_q >= $past(filled_q))
    else $error("fill count out of range or decreased");

  // the frame reported always carries a set reference bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cpr_pkg::ST_DONE |-> ref_q[slot_q])
    else $error("result frame has a clear reference bit");
`endif

endmodule

`default_nettype wire
